FILE: sv/bilinear_row_scaler_unit_defines.svh
// ---------------------------------------------------------------------------
// Bilinear row scaler - assertion macros
// Shared assertion helpers. Synthesis builds define SYNTH, which leaves
// every macro body empty.
// ---------------------------------------------------------------------------
`ifndef BILINEAR_ROW_SCALER_UNIT_DEFINES_SVH
`define BILINEAR_ROW_SCALER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Property that must hold in the same cycle.
`define BRS_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("brs assertion failed in %m");
// Consequent that must hold in the cycle after the antecedent.
`define BRS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("brs assertion failed in %m");
`else
`define BRS_ASSERT(label, clk, rstn, prop)
`define BRS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: sv/brs_pkg.sv
// ---------------------------------------------------------------------------
// Bilinear row scaler - package
// Shared widths, codes, stream layouts and controller types.
// ---------------------------------------------------------------------------
`default_nettype none

package brs_pkg;

    // Default sizes handed to the top level parameters.
    localparam int LINE_PIXELS_DEF = 4096;
    localparam int FRAC_BITS_DEF   = 16;

    // Fixed field widths.
    localparam int CHAN_W     = 8;
    localparam int NUM_CH     = 3;
    localparam int PIX_W      = CHAN_W * NUM_CH;
    localparam int COL_W      = 12;
    localparam int SCALE_W    = 20;
    localparam int WIDTH_W    = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [SCALE_W-1:0] SCALE_RST = 20'd65536;
    localparam logic [WIDTH_W-1:0] WIDTH_RST = 13'd4096;

    // Request kinds and line selectors.
    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_COMPUTE = 1'b1;
    localparam logic LINE_UPPER  = 1'b0;
    localparam logic LINE_LOWER  = 1'b1;

    // Input tdata layout, lowest field last.
    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic [COL_W-1:0]  row_index;
        logic [COL_W-1:0]  column;
    } in_data_t;

    // Output tdata layout, lowest field last.
    typedef struct packed {
        logic [3:0]        pad;
        logic [COL_W-1:0]  column;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } out_data_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_READ,
        ST_WEIGHT,
        ST_BLEND,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_wr;
        logic capture;
        logic map_en;
        logic read_en;
        logic weight_en;
        logic blend_en;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

FILE: sv/brs_ram.sv
// ---------------------------------------------------------------------------
// Bilinear row scaler - line store RAM
// Generic RAM with one write port and two registered read ports.
// ---------------------------------------------------------------------------
`default_nettype none

module brs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_a,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two registered read ports.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

FILE: sv/brs_ctrl.sv
// ---------------------------------------------------------------------------
// Bilinear row scaler - controller
// Sequences loads and the five steps of an interpolation.
// ---------------------------------------------------------------------------
`default_nettype none
`include "bilinear_row_scaler_unit_defines.svh"

module brs_ctrl
    import brs_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire logic    s_req_type,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && (s_req_type == REQ_COMPUTE)) begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:    state_next = ST_READ;
            ST_READ:   state_next = ST_WEIGHT;
            ST_WEIGHT: state_next = ST_BLEND;
            ST_BLEND:  state_next = ST_OUT;
            ST_OUT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_wr = s_tvalid && (s_req_type == REQ_LOAD);
                cmd.capture = s_tvalid && (s_req_type == REQ_COMPUTE);
            end
            ST_MAP:    cmd.map_en    = 1'b1;
            ST_READ:   cmd.read_en   = 1'b1;
            ST_WEIGHT: cmd.weight_en = 1'b1;
            ST_BLEND:  cmd.blend_en  = 1'b1;
            ST_OUT:    cmd.out_load  = status.out_free;
            default: begin
                cmd      = '0;
                s_tready = 1'b0;
            end
        endcase
    end

    // A captured compute transfer always moves on to the mapping step.
    `BRS_ASSERT_NEXT(a_capture_to_map, aclk, aresetn, cmd.capture, state_reg == ST_MAP)
    // The result is loaded only when the output slot can take it.
    `BRS_ASSERT(a_load_when_free, aclk, aresetn, !cmd.out_load || status.out_free)
    // After the result is loaded the input side opens again.
    `BRS_ASSERT_NEXT(a_load_reopens, aclk, aresetn, cmd.out_load, s_tready)

endmodule

`default_nettype wire

FILE: sv/brs_datapath.sv
// ---------------------------------------------------------------------------
// Bilinear row scaler - datapath
// Configuration registers, line stores, coordinate mapping, weighting and
// the output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "bilinear_row_scaler_unit_defines.svh"

module brs_datapath
    import brs_pkg::*;
#(
    parameter int LINE_PIXELS = LINE_PIXELS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic                  s_line_sel,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_DATA_W-1:0] m_tdata,
    output logic                       m_tlast,
    input  wire cmd_t                  cmd,
    output status_t                    status
);

    localparam int AW      = $clog2(LINE_PIXELS);
    localparam int PX_W    = COL_W + SCALE_W;
    localparam int IDX_W   = PX_W - FRAC_BITS;
    localparam int WGT_W   = FRAC_BITS + 1;
    localparam int TSUM_W  = CHAN_W + WGT_W + 1;
    localparam int TERM_W  = CHAN_W + FRAC_BITS;
    localparam int PROD_W  = TERM_W + WGT_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int VAL_W   = SUM_W - 2 * FRAC_BITS;
    localparam logic [WGT_W-1:0] ONE = WGT_W'(1) << FRAC_BITS;

    in_data_t in_d;

    logic [SCALE_W-1:0] scale_reg;
    logic [WIDTH_W-1:0] src_pixels_reg;
    logic [WIDTH_W-1:0] out_width_reg;

    logic [COL_W-1:0]     col_reg;
    logic [COL_W-1:0]     row_reg;
    logic [PX_W-1:0]      px_reg;
    logic [PX_W-1:0]      px_next;
    logic [PX_W-1:0]      py_next;
    logic [FRAC_BITS-1:0] fy_reg;

    logic [IDX_W-1:0] idx;
    logic [PX_W-1:0]  idx_ext;
    logic [PX_W-1:0]  sw_ext;
    logic [PX_W-1:0]  last_pos;
    logic [PX_W-1:0]  left_pos;
    logic [PX_W-1:0]  right_pos;
    logic             at_edge;
    logic [AW-1:0]    left_addr;
    logic [AW-1:0]    right_addr;

    logic             load_in_range;
    logic             ram_we_up;
    logic             ram_we_lo;
    logic [AW-1:0]    wr_addr;
    logic [PIX_W-1:0] wr_pix;
    logic [PIX_W-1:0] up_l;
    logic [PIX_W-1:0] up_r;
    logic [PIX_W-1:0] lo_l;
    logic [PIX_W-1:0] lo_r;

    logic [WGT_W-1:0] wx;
    logic [WGT_W-1:0] wx_inv;
    logic [WGT_W-1:0] wy;
    logic [WGT_W-1:0] wy_inv;

    logic [CHAN_W-1:0] chan_out [NUM_CH];

    out_data_t        m_data_reg;
    logic             m_valid_reg;
    logic             m_last_reg;
    logic             row_end;

    assign in_d = in_data_t'(s_tdata);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg      <= SCALE_RST;
            src_pixels_reg <= WIDTH_RST;
            out_width_reg  <= WIDTH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SCALE:     scale_reg      <= cfg_wdata[SCALE_W-1:0];
                CFG_SRC_WIDTH: src_pixels_reg <= cfg_wdata[WIDTH_W-1:0];
                CFG_OUT_WIDTH: out_width_reg  <= cfg_wdata[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // Load path: writes beyond the line store are dropped.
    assign load_in_range = PX_W'(in_d.column) < PX_W'(LINE_PIXELS);
    assign ram_we_up     = cmd.load_wr && load_in_range && (s_line_sel == LINE_UPPER);
    assign ram_we_lo     = cmd.load_wr && load_in_range && (s_line_sel == LINE_LOWER);
    assign wr_addr       = AW'(in_d.column);
    assign wr_pix        = {in_d.red, in_d.green, in_d.blue};

    // Capture the compute request.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            col_reg <= in_d.column;
            row_reg <= in_d.row_index;
        end
    end

    // Map column and row to source positions.
    assign px_next = PX_W'(col_reg) * PX_W'(scale_reg);
    assign py_next = PX_W'(row_reg) * PX_W'(scale_reg);

    always_ff @(posedge aclk) begin
        if (cmd.map_en) begin
            px_reg <= px_next;
            fy_reg <= py_next[FRAC_BITS-1:0];
        end
    end

    // Neighbour indices, with the right edge folded onto the last pixel.
    assign idx      = px_reg[PX_W-1:FRAC_BITS];
    assign idx_ext  = PX_W'(idx);
    assign sw_ext   = PX_W'(src_pixels_reg);
    assign last_pos = (src_pixels_reg == '0) ? '0 :
                      (sw_ext > PX_W'(LINE_PIXELS)) ? PX_W'(LINE_PIXELS - 1) :
                      sw_ext - PX_W'(1);
    assign at_edge   = idx_ext >= last_pos;
    assign left_pos  = at_edge ? last_pos : idx_ext;
    assign right_pos = at_edge ? last_pos : idx_ext + PX_W'(1);
    assign left_addr  = AW'(left_pos);
    assign right_addr = AW'(right_pos);

    // Line stores.
    brs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (LINE_PIXELS)
    ) u_upper_ram (
        .aclk      (aclk),
        .wr_en     (ram_we_up),
        .wr_addr   (wr_addr),
        .wr_data   (wr_pix),
        .rd_en     (cmd.read_en),
        .rd_addr_a (left_addr),
        .rd_addr_b (right_addr),
        .rd_data_a (up_l),
        .rd_data_b (up_r)
    );

    brs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (LINE_PIXELS)
    ) u_lower_ram (
        .aclk      (aclk),
        .wr_en     (ram_we_lo),
        .wr_addr   (wr_addr),
        .wr_data   (wr_pix),
        .rd_en     (cmd.read_en),
        .rd_addr_a (left_addr),
        .rd_addr_b (right_addr),
        .rd_data_a (lo_l),
        .rd_data_b (lo_r)
    );

    // Fractional weights.
    assign wx     = WGT_W'(px_reg[FRAC_BITS-1:0]);
    assign wx_inv = ONE - wx;
    assign wy     = WGT_W'(fy_reg);
    assign wy_inv = ONE - wy;

    // One lane per colour channel; lane 0 is blue, lane 2 is red.
    for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
        logic [TSUM_W-1:0] tsum_up;
        logic [TSUM_W-1:0] tsum_lo;
        logic [TERM_W-1:0] term_up_reg;
        logic [TERM_W-1:0] term_lo_reg;
        logic [PROD_W-1:0] prod_up_reg;
        logic [PROD_W-1:0] prod_lo_reg;
        logic [SUM_W-1:0]  sum;
        logic [VAL_W-1:0]  val;

        // Horizontal blend of each line.
        assign tsum_up = TSUM_W'(up_l[c*CHAN_W +: CHAN_W]) * TSUM_W'(wx_inv)
                       + TSUM_W'(up_r[c*CHAN_W +: CHAN_W]) * TSUM_W'(wx);
        assign tsum_lo = TSUM_W'(lo_l[c*CHAN_W +: CHAN_W]) * TSUM_W'(wx_inv)
                       + TSUM_W'(lo_r[c*CHAN_W +: CHAN_W]) * TSUM_W'(wx);

        always_ff @(posedge aclk) begin
            if (cmd.weight_en) begin
                term_up_reg <= TERM_W'(tsum_up);
                term_lo_reg <= TERM_W'(tsum_lo);
            end
        end

        // Vertical weighting.
        always_ff @(posedge aclk) begin
            if (cmd.blend_en) begin
                prod_up_reg <= PROD_W'(term_up_reg) * PROD_W'(wy_inv);
                prod_lo_reg <= PROD_W'(term_lo_reg) * PROD_W'(wy);
            end
        end

        // Sum, drop the fraction and clamp.
        assign sum = SUM_W'(prod_up_reg) + SUM_W'(prod_lo_reg);
        assign val = sum[SUM_W-1:2*FRAC_BITS];
        assign chan_out[c] = (val > VAL_W'(CHAN_MAX)) ? CHAN_MAX : val[CHAN_W-1:0];
    end

    // Row end flag; a zero out width never matches.
    assign row_end = (WIDTH_W'(col_reg) + WIDTH_W'(1)) == out_width_reg;

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.pad    <= '0;
            m_data_reg.column <= col_reg;
            m_data_reg.red    <= chan_out[2];
            m_data_reg.green  <= chan_out[1];
            m_data_reg.blue   <= chan_out[0];
            m_last_reg        <= row_end;
        end
    end

    assign m_tvalid        = m_valid_reg;
    assign m_tdata         = m_data_reg;
    assign m_tlast         = m_last_reg;
    assign status.out_free = !m_valid_reg || m_tready;

    // A loaded result is offered on the next cycle.
    `BRS_ASSERT_NEXT(a_out_offered, aclk, aresetn, cmd.out_load, m_tvalid)
    // Line stores are never written while they are being read.
    `BRS_ASSERT(a_no_wr_in_rd, aclk, aresetn, !((ram_we_up || ram_we_lo) && cmd.read_en))

endmodule

`default_nettype wire

FILE: sv/bilinear_row_scaler_unit.sv
// ---------------------------------------------------------------------------
// Bilinear row scaler - top level
// RGB888 bilinear scaler over two source line stores.
//
//   Channel | Direction | Handshake         | Contents
//   --------+-----------+-------------------+----------------------------------
//   cfg     | in        | cfg_wr_en         | register index, write data
//   s_      | in        | s_tvalid/s_tready | load or compute request
//   m_      | out       | m_tvalid/m_tready | interpolated pixel, row end
//
// A load is written straight into a line store and the block is ready again at once.
// A compute transfer runs through the mapping multiply, line store read,
// horizontal blend, vertical blend and output load; the two read ports
// of each line store fetch both neighbours in the single read step.
// The result register frees the input side while a result waits on m_tready;
// a stall holds the last step until the register can take the new result.
// Reset is synchronous and active low; the line stores are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module bilinear_row_scaler_unit
    import brs_pkg::*;
#(
    parameter int LINE_PIXELS = LINE_PIXELS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // column, row_index, in_red, in_green, in_blue
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // req_type, line_sel
    input  wire logic [IN_USER_W-1:0]  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // out_red, out_green, out_blue, out_column, zero fill
    output logic      [OUT_DATA_W-1:0] m_tdata,
    output logic                       m_tlast
);

    cmd_t    cmd;
    status_t status;

    brs_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_req_type (s_tuser[0]),
        .status     (status),
        .cmd        (cmd)
    );

    brs_datapath #(
        .LINE_PIXELS (LINE_PIXELS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tdata    (s_tdata),
        .s_line_sel (s_tuser[1]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

`default_nettype wire

FILE: tb/sv/bilinear_row_scaler_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Bilinear row scaler unit - testbench
// Fills the two source line stores with load transfers and sends compute
// requests whose neighbours have always been loaded beforehand. A predictor
// in the bench works out each interpolated pixel from its own copy of the
// line stores and registers. Each result transfer is checked field by field
// against the oldest predicted pixel. Both stream sides idle at random.
// The register settings are stepped through their extremes between phases.
// ---------------------------------------------------------------------------

module bilinear_row_scaler_unit_tb
    import brs_pkg::*;
();

    localparam int LINE_LEN      = LINE_PIXELS_DEF;
    localparam int FRAC          = FRAC_BITS_DEF;
    localparam int RANDOM_ITEMS  = 950;
    localparam int PHASE_ITEMS   = 80;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int COL_MAX       = (1 << COL_W) - 1;

    // Index that selects no register; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // One request as the bench sees it.
    typedef struct packed {
        logic              req_type;
        logic              line_sel;
        logic [COL_W-1:0]  column;
        logic [COL_W-1:0]  row_index;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } scaler_req_t;

    // One predicted output pixel.
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [COL_W-1:0]  column;
        logic              row_end;
    } scaled_pixel_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic [IN_USER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    // Predictor state: line stores and registers.
    logic [PIX_W-1:0]   upper_pix [LINE_LEN];
    logic [PIX_W-1:0]   lower_pix [LINE_LEN];
    logic [SCALE_W-1:0] scale_step = SCALE_RST;
    logic [WIDTH_W-1:0] src_pixels = WIDTH_RST;
    logic [WIDTH_W-1:0] dst_width  = WIDTH_RST;

    // Store entries already covered by a queued load.
    bit loaded_upper [LINE_LEN];
    bit loaded_lower [LINE_LEN];

    scaler_req_t   pending_reqs[$];
    scaled_pixel_t expected_pixels[$];

    scaler_req_t   current_req;
    in_data_t      drive_word;
    out_data_t     got_word;
    scaled_pixel_t want_pixel;
    bit            holding      = 1'b0;
    bit            in_taken     = 1'b0;
    bit            out_taken    = 1'b0;
    int            in_gap       = 0;
    int            in_calm      = 0;
    int            out_wait     = 0;
    int            out_calm     = 0;
    int            queued_total = 0;
    int            mismatch_count = 0;
    int            cycle_count  = 0;

    bilinear_row_scaler_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Left and right source neighbours and horizontal fraction of a column.
    function automatic void map_column(input logic [COL_W-1:0] col, output int left,
                                       output int right, output logic [FRAC-1:0] frac);
        logic [63:0] pos;
        int          last_pix;
        pos  = 64'(col) * 64'(scale_step);
        frac = pos[FRAC-1:0];
        if (src_pixels == 0)
            last_pix = 0;
        else if (src_pixels > LINE_LEN)
            last_pix = LINE_LEN - 1;
        else
            last_pix = int'(src_pixels) - 1;
        // At or past the right edge both neighbours are the last pixel.
        if ((pos >> FRAC) >= 64'(last_pix)) begin
            left  = last_pix;
            right = last_pix;
        end else begin
            left  = int'(pos >> FRAC);
            right = left + 1;
        end
    endfunction

    // Exact two-dimensional blend of one channel, truncated and clamped.
    function automatic logic [CHAN_W-1:0] blend_channel(
        input logic [CHAN_W-1:0] ul, input logic [CHAN_W-1:0] ur,
        input logic [CHAN_W-1:0] ll, input logic [CHAN_W-1:0] lr,
        input logic [FRAC-1:0] fx, input logic [FRAC-1:0] fy);
        logic [63:0] one_q;
        logic [63:0] top;
        logic [63:0] bottom;
        logic [63:0] mix;
        one_q  = 64'd1 << FRAC;
        top    = 64'(ul) * (one_q - 64'(fx)) + 64'(ur) * 64'(fx);
        bottom = 64'(ll) * (one_q - 64'(fx)) + 64'(lr) * 64'(fx);
        mix    = (top * (one_q - 64'(fy)) + bottom * 64'(fy)) >> (2 * FRAC);
        return (mix > 64'(CHAN_MAX)) ? CHAN_MAX : mix[CHAN_W-1:0];
    endfunction

    // Apply one accepted request: update a store or predict a pixel.
    function automatic void predict_pixel(input scaler_req_t req);
        int               left;
        int               right;
        logic [FRAC-1:0]  fx;
        logic [FRAC-1:0]  fy;
        logic [63:0]      row_pos;
        logic [PIX_W-1:0] mixed;
        scaled_pixel_t    px;
        if (req.req_type == REQ_LOAD) begin
            if (req.line_sel == LINE_LOWER)
                lower_pix[req.column] = {req.red, req.green, req.blue};
            else
                upper_pix[req.column] = {req.red, req.green, req.blue};
            return;
        end
        map_column(req.column, left, right, fx);
        row_pos = 64'(req.row_index) * 64'(scale_step);
        fy      = row_pos[FRAC-1:0];
        for (int ch = 0; ch < NUM_CH; ch++)
            mixed[ch*CHAN_W +: CHAN_W] = blend_channel(
                upper_pix[left][ch*CHAN_W +: CHAN_W], upper_pix[right][ch*CHAN_W +: CHAN_W],
                lower_pix[left][ch*CHAN_W +: CHAN_W], lower_pix[right][ch*CHAN_W +: CHAN_W],
                fx, fy);
        {px.red, px.green, px.blue} = mixed;
        px.column  = req.column;
        px.row_end = (dst_width != 0) && (WIDTH_W'(req.column) == dst_width - 1'b1);
        expected_pixels.push_back(px);
    endfunction

    // Idle cycles before the next transfer, with occasional calm stretches.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    function automatic scaler_req_t random_req(input logic kind);
        scaler_req_t r;
        r.req_type  = kind;
        r.line_sel  = 1'($urandom_range(0, 1));
        r.column    = COL_W'($urandom_range(0, COL_MAX));
        r.row_index = COL_W'($urandom_range(0, COL_MAX));
        r.red       = CHAN_W'($urandom_range(0, 255));
        r.green     = CHAN_W'($urandom_range(0, 255));
        r.blue      = CHAN_W'($urandom_range(0, 255));
        return r;
    endfunction

    function automatic void push_load(input int col, input logic sel, input logic [PIX_W-1:0] pix);
        scaler_req_t r;
        r          = random_req(REQ_LOAD);
        r.line_sel = sel;
        r.column   = COL_W'(col);
        {r.red, r.green, r.blue} = pix;
        if (sel == LINE_LOWER)
            loaded_lower[col] = 1'b1;
        else
            loaded_upper[col] = 1'b1;
        pending_reqs.push_back(r);
        queued_total++;
    endfunction

    // A compute request, preceded by loads of any neighbour not yet loaded.
    // With refresh set, neighbours are sometimes reloaded with fresh content.
    function automatic void push_compute(input logic [COL_W-1:0] col,
                                         input logic [COL_W-1:0] row, input bit refresh);
        scaler_req_t     r;
        int              left;
        int              right;
        logic [FRAC-1:0] fx;
        map_column(col, left, right, fx);
        if (!loaded_upper[left] || (refresh && $urandom_range(0, 3) == 0))
            push_load(left, LINE_UPPER, PIX_W'($urandom));
        if (!loaded_lower[left] || (refresh && $urandom_range(0, 3) == 0))
            push_load(left, LINE_LOWER, PIX_W'($urandom));
        if (!loaded_upper[right] || (refresh && $urandom_range(0, 3) == 0))
            push_load(right, LINE_UPPER, PIX_W'($urandom));
        if (!loaded_lower[right] || (refresh && $urandom_range(0, 3) == 0))
            push_load(right, LINE_LOWER, PIX_W'($urandom));
        r           = random_req(REQ_COMPUTE);
        r.column    = col;
        r.row_index = row;
        pending_reqs.push_back(r);
        queued_total++;
    endfunction

    // Wait until every request has been taken and every pixel returned.
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || holding || expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_SCALE:     scale_step = value[SCALE_W-1:0];
            CFG_SRC_WIDTH: src_pixels = value[WIDTH_W-1:0];
            CFG_OUT_WIDTH: dst_width  = value[WIDTH_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Input driver: presents the next queued request after a random gap.
    always @(negedge aclk) begin
        if (in_taken) begin
            in_taken = 1'b0;
            holding  = 1'b0;
        end
        if (aresetn && !holding) begin
            if (in_gap > 0) begin
                in_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                current_req          = pending_reqs.pop_front();
                drive_word.column    = current_req.column;
                drive_word.row_index = current_req.row_index;
                drive_word.red       = current_req.red;
                drive_word.green     = current_req.green;
                drive_word.blue      = current_req.blue;
                s_tdata  <= drive_word;
                s_tuser  <= {current_req.line_sel, current_req.req_type};
                s_tvalid <= 1'b1;
                holding  = 1'b1;
                in_gap   = draw_wait(in_calm);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Input transfer seen: update the predictor.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            predict_pixel(current_req);
            in_taken = 1'b1;
        end
    end

    // Result side back-pressure: a random stall after each transfer.
    always @(negedge aclk) begin
        if (out_taken) begin
            out_taken = 1'b0;
            out_wait  = draw_wait(out_calm);
        end
        if (out_wait > 0) begin
            out_wait--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result monitor: compare each transfer with the oldest predicted pixel.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_word = m_tdata;
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected result, column", got_word.column, 0);
            end else begin
                want_pixel = expected_pixels.pop_front();
                if (got_word.red != want_pixel.red)
                    report_mismatch("red", got_word.red, want_pixel.red);
                if (got_word.green != want_pixel.green)
                    report_mismatch("green", got_word.green, want_pixel.green);
                if (got_word.blue != want_pixel.blue)
                    report_mismatch("blue", got_word.blue, want_pixel.blue);
                if (got_word.column != want_pixel.column)
                    report_mismatch("column", got_word.column, want_pixel.column);
                if (m_tlast != want_pixel.row_end)
                    report_mismatch("row end", m_tlast, want_pixel.row_end);
                if (got_word.pad != '0)
                    report_mismatch("zero fill", got_word.pad, 0);
            end
            out_taken = 1'b1;
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("bilinear_row_scaler_unit_tb: done, errors");
        $finish;
    end

    // Stimulus: reset, directed cases, then random phases.
    initial begin
        int                 phase;
        int                 target;
        int                 roll;
        int                 col_hi;
        logic [COL_W-1:0]   col;
        logic [SCALE_W-1:0] new_scale;
        logic [WIDTH_W-1:0] new_src;
        logic [WIDTH_W-1:0] new_dst;

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Extreme pixels at both ends of the lines, under the reset settings.
        push_load(0, LINE_UPPER, 24'hFFFFFF);
        push_load(0, LINE_LOWER, 24'h000000);
        push_load(1, LINE_UPPER, 24'h000000);
        push_load(1, LINE_LOWER, 24'hFFFFFF);
        push_load(2, LINE_UPPER, 24'hA55AFF);
        push_load(2, LINE_LOWER, 24'h00FF80);
        push_load(LINE_LEN - 2, LINE_UPPER, 24'h123456);
        push_load(LINE_LEN - 2, LINE_LOWER, 24'hFEDCBA);
        push_load(LINE_LEN - 1, LINE_UPPER, 24'hFFFFFF);
        push_load(LINE_LEN - 1, LINE_LOWER, 24'hFFFFFF);
        push_compute(0, 0, 1'b0);
        push_compute(1, 0, 1'b0);
        push_compute(COL_MAX - 1, COL_MAX, 1'b0);
        // Right edge, also the last column of a row.
        push_compute(COL_MAX, COL_MAX, 1'b0);

        // Half-pixel fractions, and the right edge reached from beyond.
        wait_idle();
        write_reg(CFG_SCALE, 20'd98304);
        push_compute(1, 1, 1'b0);
        push_compute(0, COL_MAX, 1'b0);
        push_compute(COL_MAX, COL_MAX, 1'b0);

        // Largest fractions in both directions.
        wait_idle();
        write_reg(CFG_SCALE, 20'd65535);
        push_compute(1, 1, 1'b0);

        phase        = 0;
        queued_total = 0;
        while (queued_total < RANDOM_ITEMS) begin
            case (phase)
                0: begin
                    new_scale = 20'hFFFFF;  new_src = 13'd4096; new_dst = 13'd4096;
                    col_hi = COL_MAX;
                end
                1: begin
                    // Zero scale, widths of zero and above the line length.
                    new_scale = 20'd0;      new_src = 13'd8191; new_dst = 13'd0;
                    col_hi = COL_MAX;
                end
                2: begin
                    new_scale = 20'd1;      new_src = 13'd1;    new_dst = 13'd1;
                    col_hi = COL_MAX;
                end
                3: begin
                    new_scale = 20'd32768;  new_src = 13'd16;   new_dst = 13'd4096;
                    col_hi = 63;
                end
                4: begin
                    new_scale = 20'd65535;  new_src = 13'd0;    new_dst = 13'd8191;
                    col_hi = 255;
                end
                5: begin
                    new_scale = 20'd131072; new_src = 13'd4096; new_dst = 13'd2048;
                    col_hi = COL_MAX;
                end
                default: begin
                    new_scale = ($urandom_range(0, 3) == 0) ? SCALE_W'($urandom_range(0, 1048575))
                                                             : SCALE_W'($urandom_range(0, 262143));
                    new_src = ($urandom_range(0, 3) == 0) ? WIDTH_W'($urandom_range(0, 8191))
                                                           : WIDTH_W'($urandom_range(1, 64));
                    new_dst = ($urandom_range(0, 7) == 0) ? WIDTH_W'($urandom_range(0, 8191))
                                                           : WIDTH_W'($urandom_range(0, 4096));
                    col_hi = ($urandom_range(0, 1) == 0) ? COL_MAX : $urandom_range(15, 255);
                end
            endcase

            wait_idle();
            write_reg(CFG_SCALE, CFG_DATA_W'(new_scale));
            write_reg(CFG_SRC_WIDTH, CFG_DATA_W'(new_src));
            write_reg(CFG_OUT_WIDTH, CFG_DATA_W'(new_dst));
            if (phase == 3)
                write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));

            // Mostly load-then-compute sequences, some stray loads.
            target = queued_total + PHASE_ITEMS;
            while (queued_total < target) begin
                roll = $urandom_range(0, 15);
                if (roll < 2) begin
                    push_load($urandom_range(0, LINE_LEN - 1), 1'($urandom_range(0, 1)),
                              PIX_W'($urandom));
                end else begin
                    if (roll == 2 && dst_width != 0 && dst_width <= LINE_LEN)
                        col = COL_W'(dst_width - 1'b1);
                    else if (roll == 3)
                        col = ($urandom_range(0, 1) == 0) ? COL_W'(0) : COL_W'(COL_MAX);
                    else
                        col = COL_W'($urandom_range(0, col_hi));
                    push_compute(col, COL_W'($urandom_range(0, COL_MAX)), 1'b1);
                end
            end
            phase++;
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("bilinear_row_scaler_unit_tb: done, clean");
        else
            $display("bilinear_row_scaler_unit_tb: done, errors");
        $finish;
    end

endmodule
